>>> rtl/fingerprint_segment_table_core_macros.svh
`ifndef FINGERPRINT_SEGMENT_TABLE_CORE_MACROS_SVH
`define FINGERPRINT_SEGMENT_TABLE_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define FST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define FST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fst_pkg.sv
package fst_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int SEG_W    = 10;
   localparam int TOTAL_W  = 11;
   localparam int CMP_W    = (POS_W > COUNT_W) ? POS_W : COUNT_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = QPTR_W + 1;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // work codes handed from the front to the back
   localparam logic [1:0] OP_REPLY  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_SEARCH = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] position;
      logic [63:0]      fp_upper;
      logic [63:0]      fp_middle;
      logic [31:0]      fp_lower;
      logic [31:0]      block_offset;
      logic [31:0]      segment_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEG_W-1:0]    segment_number;
      logic [63:0]         out_fp_upper;
      logic [63:0]         out_fp_middle;
      logic [31:0]         out_fp_lower;
      logic [31:0]         out_block_offset;
      logic [31:0]         out_segment_size;
      logic [TOTAL_W-1:0]  entry_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0] fp_upper;
      logic [63:0] fp_middle;
      logic [31:0] fp_lower;
      logic [31:0] block_offset;
      logic [31:0] segment_size;
   } entry_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
      logic [COUNT_W-1:0]  total;
      entry_type           entry;
   } work_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
   } front_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage

>>> rtl/fst_ram.sv
module fst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fst_front.sv
module fst_front
   import fst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic             queue_full,
   output logic             push,
   output work_type         push_item,
   output front_status_type status
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               table_full;
   logic               in_range;

   assign req_stall  = queue_full;
   assign push       = req_valid && !queue_full;
   assign table_full = (count_ff == COUNT_W'(TABLE_DEPTH));
   assign in_range   = (CMP_W'(req_data.position) < CMP_W'(count_ff));

   always_comb begin
      push_item.op                 = OP_REPLY;
      push_item.status             = STATUS_OK;
      push_item.addr               = '0;
      push_item.total              = count_ff;
      push_item.entry.fp_upper     = req_data.fp_upper;
      push_item.entry.fp_middle    = req_data.fp_middle;
      push_item.entry.fp_lower     = req_data.fp_lower;
      push_item.entry.block_offset = req_data.block_offset;
      push_item.entry.segment_size = req_data.segment_size;
      unique case (req_data.command)
         CMD_APPEND: begin
            if (table_full) begin
               push_item.status = STATUS_FULL;
            end else begin
               push_item.op    = OP_APPEND;
               push_item.addr  = ADDR_W'(count_ff);
               push_item.total = count_ff + COUNT_W'(1);
            end
         end
         CMD_READ: begin
            if (in_range) begin
               push_item.op   = OP_READ;
               push_item.addr = ADDR_W'(req_data.position);
            end else begin
               push_item.status = STATUS_NOT_FOUND;
            end
         end
         CMD_SEARCH: begin
            push_item.op = OP_SEARCH;
         end
         CMD_CLEAR: begin
            push_item.total = '0;
         end
      endcase
   end

   // the count is settled at acceptance so the back never has to feed it forward
   assign count_in = push ? push_item.total : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.count = count_ff;

endmodule

>>> rtl/fst_queue.sv
module fst_queue
   import fst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output work_type pop_item
);

   work_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff;
   logic [QFILL_W-1:0] fill_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/fst_back.sv
module fst_back
   import fst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            work_valid,
   input  work_type        work_item,
   output logic            work_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   output back_status_type status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   work_type          cur_ff;
   work_type          cur_in;
   logic [ADDR_W-1:0] check_ff;
   logic [ADDR_W-1:0] check_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              out_load;

   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;
   logic              fp_hit;
   logic              scan_last;

   fst_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(work_item.addr),
      .wr_data(work_item.entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign fp_hit = (rd_data.fp_upper == cur_ff.entry.fp_upper) &&
                   (rd_data.fp_middle == cur_ff.entry.fp_middle) &&
                   (rd_data.fp_lower == cur_ff.entry.fp_lower);
   assign scan_last = ((COUNT_W'(check_ff) + COUNT_W'(1)) == cur_ff.total);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      check_in = check_ff;
      work_pop = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = ADDR_W'(check_ff + ADDR_W'(1));
      out_load = 1'b0;
      rsp_in   = '0;
      rsp_in.entry_total = TOTAL_W'(cur_ff.total);
      unique case (state_ff)
         S_IDLE: begin
            rsp_in.entry_total = TOTAL_W'(work_item.total);
            if (work_valid && !rsp_valid_ff) begin
               work_pop = 1'b1;
               cur_in   = work_item;
               unique case (work_item.op)
                  OP_REPLY: begin
                     out_load      = 1'b1;
                     rsp_in.status = work_item.status;
                  end
                  OP_APPEND: begin
                     wr_en                 = 1'b1;
                     out_load              = 1'b1;
                     rsp_in.status         = STATUS_OK;
                     rsp_in.segment_number = SEG_W'(work_item.addr);
                  end
                  OP_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = work_item.addr;
                     state_in = S_READ;
                  end
                  OP_SEARCH: begin
                     if (work_item.total == '0) begin
                        out_load      = 1'b1;
                        rsp_in.status = STATUS_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        check_in = '0;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            out_load                = 1'b1;
            rsp_in.status           = STATUS_OK;
            rsp_in.segment_number   = SEG_W'(cur_ff.addr);
            rsp_in.out_fp_upper     = rd_data.fp_upper;
            rsp_in.out_fp_middle    = rd_data.fp_middle;
            rsp_in.out_fp_lower     = rd_data.fp_lower;
            rsp_in.out_block_offset = rd_data.block_offset;
            rsp_in.out_segment_size = rd_data.segment_size;
            state_in                = S_IDLE;
         end
         S_SCAN: begin
            // compare the entry just read while fetching the next one
            priority if (fp_hit) begin
               out_load                = 1'b1;
               rsp_in.status           = STATUS_OK;
               rsp_in.segment_number   = SEG_W'(check_ff);
               rsp_in.out_fp_upper     = rd_data.fp_upper;
               rsp_in.out_fp_middle    = rd_data.fp_middle;
               rsp_in.out_fp_lower     = rd_data.fp_lower;
               rsp_in.out_block_offset = rd_data.block_offset;
               rsp_in.out_segment_size = rd_data.segment_size;
               state_in                = S_IDLE;
            end else if (scan_last) begin
               out_load      = 1'b1;
               rsp_in.status = STATUS_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               check_in = ADDR_W'(check_ff + ADDR_W'(1));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      check_ff <= check_in;
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign status.busy = (state_ff != S_IDLE);

endmodule

>>> rtl/fingerprint_segment_table_core.sv
// segment table of a deduplication container: up to TABLE_DEPTH entries of
// 160-bit fingerprint, block offset and segment size, numbered by position
// req channel: one command per transfer (append, read by position, search
// by fingerprint, clear); rsp channel: exactly one result per command, in
// command order, with the entry count after that command
// a front stage classifies each command and keeps the entry count, a
// two-entry queue hands the work to a back sequencer that owns the table ram
// the result of append, clear, full, out of range and empty-table search is
// registered when the back takes the command from the queue; a read result
// is registered after the table ram read; a search compares the entries up
// to the first match, at most TABLE_DEPTH of them, one entry per cycle, as
// set by the read port of the table ram
// the back takes a new command only while no rsp is held valid
// reset empties the queue and the count; the ram is not cleared, since
// only positions written since the last clear are ever read
// a stalled rsp holds its payload; the front keeps taking commands until
// the queue fills, then raises req_stall
`include "fingerprint_segment_table_core_macros.svh"

module fingerprint_segment_table_core
   import fst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             push;
   work_type         push_item;
   logic             queue_full;
   logic             work_pop;
   logic             work_valid;
   work_type         work_item;
   front_status_type front_status;
   back_status_type  back_status;

   fst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .queue_full(queue_full),
      .push      (push),
      .push_item (push_item),
      .status    (front_status)
   );

   fst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (queue_full),
      .pop      (work_pop),
      .pop_valid(work_valid),
      .pop_item (work_item)
   );

   fst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .work_valid(work_valid),
      .work_item (work_item),
      .work_pop  (work_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

   `FST_ASSERT_NOW(a_busy_no_rsp, clock, reset, back_status.busy, !rsp_valid, "rsp valid during scan or read")
   `FST_ASSERT_NEXT(a_clear_count, clock, reset, req_valid && !req_stall && req_data.command == CMD_CLEAR, front_status.count == '0, "count not zero after clear")
   `FST_ASSERT_NOW(a_full_total, clock, reset, rsp_valid && rsp_data.status == STATUS_FULL, rsp_data.entry_total == TOTAL_W'(TABLE_DEPTH), "full reported below depth")

endmodule
